[hdl/rc4_pkg.sv]
`timescale 1ns / 1ps

package rc4_pkg;

   localparam int BYTE_W        = 8;
   localparam int PERM_DEPTH    = 256;
   localparam int MAX_KEY_BYTES = 16;
   localparam int REG_KEY_BYTES = 16;
   localparam int KEY_WORD_W    = 64;
   localparam int KEY_LEN_W     = 5;
   localparam int KEY_POS_W     = $clog2(REG_KEY_BYTES);
   localparam int CMD_W         = 2;
   localparam int CSR_IDX_W     = 2;

   // key length clamps to whichever is smaller: the limit or the bytes held in registers
   localparam int KEY_LEN_MAX_INT =
      (MAX_KEY_BYTES < REG_KEY_BYTES) ? MAX_KEY_BYTES : REG_KEY_BYTES;
   localparam logic [KEY_LEN_W-1:0] KEY_LEN_MAX = KEY_LEN_W'(KEY_LEN_MAX_INT);

   typedef logic [BYTE_W-1:0] byte_type;

   typedef enum logic [CMD_W-1:0] {
      CMD_DATA    = 2'd0,
      CMD_REKEY   = 2'd1,
      CMD_RESTART = 2'd2
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_KEY_LENGTH = 2'd0,
      REG_KEY_LOW    = 2'd1,
      REG_KEY_HIGH   = 2'd2
   } csr_idx_type;

endpackage

[hdl/rc4_req_if.sv]
`timescale 1ns / 1ps

interface rc4_req_if
   import rc4_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic [CMD_W-1:0] cmd;
   byte_type         data_in;

   modport source (output valid, output cmd, output data_in, input ready);
   modport sink   (input valid, input cmd, input data_in, output ready);
endinterface

[hdl/rc4_rsp_if.sv]
`timescale 1ns / 1ps

interface rc4_rsp_if
   import rc4_pkg::*;
   ();
   logic     valid;
   logic     ready;
   byte_type data_out;

   modport source (output valid, output data_out, input ready);
   modport sink   (input valid, input data_out, output ready);
endinterface

[hdl/rc4_csr_if.sv]
`timescale 1ns / 1ps

interface rc4_csr_if
   import rc4_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [KEY_WORD_W-1:0] wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

[hdl/rc4_stream_cipher.sv]
`timescale 1ns / 1ps

// RC4 stream cipher. The permutation lives in a 256 x 8 synchronous RAM (one write port,
// one registered read port), with a second RAM holding the copy taken at rekey time.
// A data item (cmd 0) makes three dependent RAM reads (S[i], S[j], S[S[i]+S[j]]) and the
// two swap writes, and returns one result; the result sits in an output register so the
// next item can be taken while it waits, though the last step holds while an earlier
// result is not yet taken. A rekey item (cmd 1) makes a pass writing the identity into
// both RAMs, then one key-schedule step per entry (read S[i], read S[j], two writes
// mirrored into the saved copy). A restart item (cmd 2) copies the saved permutation
// back, one read and one write per entry. Rekey and restart give no result; cmd 3 is taken
// and ignored. Key registers are to be written only while the block is idle; the block
// does not enforce this. The permutation holds nothing meaningful until the first rekey.
module rc4_stream_cipher
   import rc4_pkg::*;
(
   input logic        clock,
   input logic        reset,
   rc4_req_if.sink    req_ch,
   rc4_rsp_if.source  rsp_ch,
   rc4_csr_if.sink    csr_ch
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT,
      ST_KS_RD_I,
      ST_KS_RD_J,
      ST_KS_WR_I,
      ST_KS_WR_J,
      ST_CP_RD,
      ST_CP_WR,
      ST_GEN_RD_I,
      ST_GEN_RD_J,
      ST_GEN_RD_T,
      ST_GEN_OUT
   } state_type;

   localparam int ADDR_W = $clog2(PERM_DEPTH);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(PERM_DEPTH - 1);

   // registers
   state_type             state_ff, state_in;
   logic [ADDR_W-1:0]     cnt_ff, cnt_in;
   byte_type              idx_i_ff, idx_i_in;
   byte_type              idx_j_ff, idx_j_in;
   byte_type              si_ff, si_in;
   byte_type              sj_ff, sj_in;
   byte_type              t_ff, t_in;
   byte_type              data_ff, data_in;
   logic [KEY_POS_W-1:0]  key_pos_ff, key_pos_in;
   logic [KEY_LEN_W-1:0]  klen_ff, klen_in;
   logic [KEY_LEN_W-1:0]  key_len_ff, key_len_in;
   logic [KEY_WORD_W-1:0] key_lo_ff, key_lo_in;
   logic [KEY_WORD_W-1:0] key_hi_ff, key_hi_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   byte_type              rsp_data_ff, rsp_data_in;

   // memories
   byte_type          perm_mem [PERM_DEPTH];
   byte_type          save_mem [PERM_DEPTH];
   byte_type          perm_rd_ff;
   byte_type          save_rd_ff;
   logic              perm_we;
   logic              save_we;
   logic [ADDR_W-1:0] perm_waddr;
   byte_type          perm_wdata;
   logic [ADDR_W-1:0] perm_raddr;

   // combinational helpers
   logic [2*KEY_WORD_W-1:0] key_all;
   byte_type                key_byte;
   logic [KEY_LEN_W-1:0]    key_pos_next;
   byte_type                j_sum;
   byte_type                ks_byte;
   logic                    rsp_free;

   assign req_ch.ready    = (state_ff == ST_IDLE);
   assign csr_ch.ready    = 1'b1;
   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.data_out = rsp_data_ff;

   assign key_all      = {key_hi_ff, key_lo_ff};
   assign key_byte     = (klen_ff == '0) ? '0 : key_all[{key_pos_ff, 3'b000} +: BYTE_W];
   assign key_pos_next = {1'b0, key_pos_ff} + KEY_LEN_W'(1);
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;

   // S[t] after the swap: forward the swapped values, the RAM still holds the old ones
   assign ks_byte = (t_ff == idx_i_ff) ? sj_ff :
                    (t_ff == idx_j_ff) ? si_ff : perm_rd_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      idx_i_in     = idx_i_ff;
      idx_j_in     = idx_j_ff;
      si_in        = si_ff;
      sj_in        = sj_ff;
      t_in         = t_ff;
      data_in      = data_ff;
      key_pos_in   = key_pos_ff;
      klen_in      = klen_ff;
      key_len_in   = key_len_ff;
      key_lo_in    = key_lo_ff;
      key_hi_in    = key_hi_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_data_in  = rsp_data_ff;
      perm_we      = 1'b0;
      save_we      = 1'b0;
      perm_waddr   = cnt_ff;
      perm_wdata   = cnt_ff;
      perm_raddr   = cnt_ff;
      j_sum        = idx_j_ff + perm_rd_ff;

      if (csr_ch.valid) begin
         case (csr_idx_type'(csr_ch.index))
            REG_KEY_LENGTH: key_len_in = csr_ch.wdata[KEY_LEN_W-1:0];
            REG_KEY_LOW:    key_lo_in  = csr_ch.wdata;
            REG_KEY_HIGH:   key_hi_in  = csr_ch.wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               data_in = req_ch.data_in;
               case (cmd_type'(req_ch.cmd))
                  CMD_DATA: begin
                     idx_i_in = idx_i_ff + 8'd1;
                     state_in = ST_GEN_RD_I;
                  end
                  CMD_REKEY: begin
                     cnt_in     = '0;
                     idx_j_in   = '0;
                     key_pos_in = '0;
                     klen_in    = (key_len_ff > KEY_LEN_MAX) ? KEY_LEN_MAX : key_len_ff;
                     state_in   = ST_INIT;
                  end
                  CMD_RESTART: begin
                     cnt_in   = '0;
                     state_in = ST_CP_RD;
                  end
                  default: ;
               endcase
            end
         end
         ST_INIT: begin
            perm_we = 1'b1;
            save_we = 1'b1;
            cnt_in  = cnt_ff + ADDR_W'(1);
            if (cnt_ff == LAST_ADDR) begin
               state_in = ST_KS_RD_I;
            end
         end
         ST_KS_RD_I: begin
            state_in = ST_KS_RD_J;
         end
         ST_KS_RD_J: begin
            j_sum      = idx_j_ff + perm_rd_ff + key_byte;
            idx_j_in   = j_sum;
            perm_raddr = j_sum;
            si_in      = perm_rd_ff;
            if (klen_ff != '0) begin
               key_pos_in = (key_pos_next >= klen_ff) ? '0 : key_pos_next[KEY_POS_W-1:0];
            end
            state_in = ST_KS_WR_I;
         end
         ST_KS_WR_I: begin
            perm_we    = 1'b1;
            save_we    = 1'b1;
            perm_wdata = perm_rd_ff;
            state_in   = ST_KS_WR_J;
         end
         ST_KS_WR_J: begin
            perm_we    = 1'b1;
            save_we    = 1'b1;
            perm_waddr = idx_j_ff;
            perm_wdata = si_ff;
            cnt_in     = cnt_ff + ADDR_W'(1);
            if (cnt_ff == LAST_ADDR) begin
               idx_i_in = '0;
               idx_j_in = '0;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_KS_RD_I;
            end
         end
         ST_CP_RD: begin
            state_in = ST_CP_WR;
         end
         ST_CP_WR: begin
            perm_we    = 1'b1;
            perm_wdata = save_rd_ff;
            cnt_in     = cnt_ff + ADDR_W'(1);
            if (cnt_ff == LAST_ADDR) begin
               idx_i_in = '0;
               idx_j_in = '0;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_CP_RD;
            end
         end
         ST_GEN_RD_I: begin
            perm_raddr = idx_i_ff;
            state_in   = ST_GEN_RD_J;
         end
         ST_GEN_RD_J: begin
            idx_j_in   = j_sum;
            perm_raddr = j_sum;
            si_in      = perm_rd_ff;
            state_in   = ST_GEN_RD_T;
         end
         ST_GEN_RD_T: begin
            sj_in      = perm_rd_ff;
            perm_we    = 1'b1;
            perm_waddr = idx_i_ff;
            perm_wdata = perm_rd_ff;
            t_in       = si_ff + perm_rd_ff;
            perm_raddr = si_ff + perm_rd_ff;
            state_in   = ST_GEN_OUT;
         end
         ST_GEN_OUT: begin
            // write is idempotent, so holding here on a stalled output is harmless
            perm_we    = 1'b1;
            perm_waddr = idx_j_ff;
            perm_wdata = si_ff;
            perm_raddr = t_ff;
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = data_ff ^ ks_byte;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         idx_i_ff     <= '0;
         idx_j_ff     <= '0;
         key_pos_ff   <= '0;
         klen_ff      <= '0;
         key_len_ff   <= '0;
         key_lo_ff    <= '0;
         key_hi_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         idx_i_ff     <= idx_i_in;
         idx_j_ff     <= idx_j_in;
         key_pos_ff   <= key_pos_in;
         klen_ff      <= klen_in;
         key_len_ff   <= key_len_in;
         key_lo_ff    <= key_lo_in;
         key_hi_ff    <= key_hi_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      si_ff       <= si_in;
      sj_ff       <= sj_in;
      t_ff        <= t_in;
      data_ff     <= data_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (perm_we) begin
         perm_mem[perm_waddr] <= perm_wdata;
      end
      perm_rd_ff <= perm_mem[perm_raddr];
   end

   always_ff @(posedge clock) begin
      if (save_we) begin
         save_mem[perm_waddr] <= perm_wdata;
      end
      save_rd_ff <= save_mem[cnt_ff];
   end

endmodule

[dv/rc4_cipher_checker.sv]
`timescale 1ns / 1ps

module rc4_cipher_checker
   import rc4_pkg::*;
(
   input  logic clock,
   input  logic reset,
   rc4_req_if   req_mon,
   rc4_rsp_if   rsp_mon,
   rc4_csr_if   csr_mon,
   output int   mismatches,
   output int   outstanding
);

   byte_type              sbox [PERM_DEPTH];
   byte_type              sbox_saved [PERM_DEPTH];
   byte_type              ks_i;
   byte_type              ks_j;
   logic [KEY_LEN_W-1:0]  key_len;
   logic [KEY_WORD_W-1:0] key_lo;
   logic [KEY_WORD_W-1:0] key_hi;
   byte_type              cipher_q [$];
   int                    fails;

   task automatic schedule_key();
      int       n;
      int       j;
      int       k;
      byte_type kb;
      byte_type t;
      n = (key_len > KEY_LEN_MAX) ? KEY_LEN_MAX_INT : int'(key_len);
      for (int i = 0; i < PERM_DEPTH; i++)
         sbox[i] = byte_type'(i);
      j = 0;
      k = 0;
      for (int i = 0; i < PERM_DEPTH; i++) begin
         if (n == 0)
            kb = '0;
         else if (k < 8)
            kb = key_lo[k*8 +: 8];
         else
            kb = key_hi[(k-8)*8 +: 8];
         j = (j + sbox[i] + kb) & 8'hff;
         t = sbox[i];
         sbox[i] = sbox[j];
         sbox[j] = t;
         if (n != 0) begin
            k++;
            if (k >= n)
               k = 0;
         end
      end
      sbox_saved = sbox;
      ks_i = '0;
      ks_j = '0;
   endtask

   function automatic byte_type next_keystream();
      byte_type t;
      ks_i = ks_i + 8'd1;
      ks_j = ks_j + sbox[ks_i];
      t = sbox[ks_i];
      sbox[ks_i] = sbox[ks_j];
      sbox[ks_j] = t;
      return sbox[byte_type'(sbox[ks_i] + sbox[ks_j])];
   endfunction

   always @(posedge clock) begin
      byte_type want;
      if (reset) begin
         ks_i = '0;
         ks_j = '0;
         key_len = '0;
         key_lo = '0;
         key_hi = '0;
         cipher_q.delete();
         fails = 0;
      end else begin
         // results are checked before new items are queued: no item answers in its own cycle
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (cipher_q.size() == 0) begin
               fails++;
               $display("%0t: unexpected data_out: expected none, got %02h",
                        $time, rsp_mon.data_out);
            end else begin
               want = cipher_q.pop_front();
               if (rsp_mon.data_out !== want) begin
                  fails++;
                  $display("%0t: data_out mismatch: expected %02h, got %02h",
                           $time, want, rsp_mon.data_out);
               end
            end
         end
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_idx_type'(csr_mon.index))
               REG_KEY_LENGTH: key_len = csr_mon.wdata[KEY_LEN_W-1:0];
               REG_KEY_LOW:    key_lo = csr_mon.wdata;
               REG_KEY_HIGH:   key_hi = csr_mon.wdata;
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            case (cmd_type'(req_mon.cmd))
               CMD_DATA:  cipher_q.push_back(req_mon.data_in ^ next_keystream());
               CMD_REKEY: schedule_key();
               CMD_RESTART: begin
                  sbox = sbox_saved;
                  ks_i = '0;
                  ks_j = '0;
               end
               default: ;
            endcase
         end
      end
      mismatches  <= fails;
      outstanding <= cipher_q.size();
   end

endmodule

[dv/tb_rc4_stream_cipher.sv]
`timescale 1ns / 1ps

module tb_rc4_stream_cipher;
   import rc4_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES   = 1500;   // longer than a rekey pass
   localparam int HOLD_CYCLES     = 300;
   localparam int WATCHDOG_LIMIT  = 20000;
   localparam int PHASE_ITEMS     = 92;

   logic clock;
   logic reset;
   bit   idle_on;
   bit   hold_rsp;
   int   mismatches;
   int   outstanding;
   int   quiet_cycles;

   rc4_req_if req_ch ();
   rc4_rsp_if rsp_ch ();
   rc4_csr_if csr_ch ();

   rc4_stream_cipher i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   rc4_cipher_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_ch),
      .rsp_mon     (rsp_ch),
      .csr_mon     (csr_ch),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // result side: random back-pressure, plus one long hold-off on request
   initial begin
      int burst;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            burst = $urandom_range(1, 6);
            rsp_ch.ready <= 1'b0;
            repeat (burst - 1) @(negedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   task automatic send_item(input logic [CMD_W-1:0] c, input byte_type d);
      int gap;
      gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
      @(negedge clock);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.cmd     <= c;
      req_ch.data_in <= d;
      do
         @(posedge clock);
      while (!req_ch.ready);
   endtask

   task automatic req_idle();
      @(negedge clock);
      req_ch.valid <= 1'b0;
   endtask

   task automatic write_reg(input csr_idx_type idx, input logic [KEY_WORD_W-1:0] value);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.wdata <= value;
      do
         @(posedge clock);
      while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // a rekey or restart may still be running after the last result
   task automatic wait_quiet();
      while (outstanding != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_key(input int len, input logic [KEY_WORD_W-1:0] lo,
                           input logic [KEY_WORD_W-1:0] hi);
      wait_quiet();
      write_reg(REG_KEY_LENGTH, KEY_WORD_W'(len));
      write_reg(REG_KEY_LOW, lo);
      write_reg(REG_KEY_HIGH, hi);
   endtask

   function automatic logic [KEY_WORD_W-1:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   task automatic random_phase(input bit squeeze);
      int                 counted;
      int                 r;
      logic [CMD_W-1:0]   c;
      send_item(CMD_REKEY, byte_type'($urandom));
      counted = 1;
      if (squeeze) begin
         send_item(CMD_DATA, byte_type'($urandom));
         hold_rsp = 1'b1;
         // keep offering data so the block backs up against the stalled output
         repeat (8) send_item(CMD_DATA, byte_type'($urandom));
         counted += 9;
      end
      while (counted < PHASE_ITEMS) begin
         r = $urandom_range(0, 99);
         if (r < 80)
            c = CMD_DATA;
         else if (r < 87)
            c = CMD_RESTART;
         else if (r < 92)
            c = CMD_REKEY;
         else
            c = CMD_UNUSED;
         send_item(c, byte_type'($urandom));
         if (c != CMD_UNUSED)
            counted++;
      end
      req_idle();
   endtask

   initial begin
      req_ch.valid   = 1'b0;
      req_ch.cmd     = CMD_DATA;
      req_ch.data_in = '0;
      csr_ch.valid   = 1'b0;
      csr_ch.index   = REG_KEY_LENGTH;
      csr_ch.wdata   = '0;
      idle_on        = 1'b1;
      hold_rsp       = 1'b0;
      reset          = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // zero-length key: one zero byte; restart must replay the same keystream
      load_key(0, '0, '0);
      send_item(CMD_REKEY, 8'h00);
      send_item(CMD_DATA, 8'h00);
      send_item(CMD_DATA, 8'hff);
      send_item(CMD_UNUSED, 8'ha5);
      send_item(CMD_DATA, 8'h5a);
      send_item(CMD_RESTART, 8'h00);
      send_item(CMD_DATA, 8'h00);
      send_item(CMD_DATA, 8'hff);
      req_idle();

      load_key(16, '1, '1);
      send_item(CMD_REKEY, 8'hff);
      send_item(CMD_DATA, 8'h00);
      send_item(CMD_DATA, 8'hff);
      send_item(CMD_RESTART, 8'hff);
      send_item(CMD_DATA, 8'h80);
      req_idle();

      // lengths beyond the register bytes clamp to 16
      load_key(31, rand_word(), rand_word());
      send_item(CMD_REKEY, 8'h00);
      send_item(CMD_DATA, 8'h01);
      send_item(CMD_DATA, 8'hfe);
      req_idle();

      load_key(17, rand_word(), rand_word());
      send_item(CMD_REKEY, 8'h00);
      send_item(CMD_DATA, 8'h00);
      req_idle();

      load_key(1, rand_word(), '0);
      send_item(CMD_REKEY, 8'h00);
      send_item(CMD_DATA, 8'h7f);
      send_item(CMD_REKEY, 8'h00);
      send_item(CMD_DATA, 8'h00);
      req_idle();

      load_key(16, rand_word(), rand_word());
      random_phase(1'b1);
      load_key($urandom_range(1, 15), rand_word(), rand_word());
      random_phase(1'b0);
      load_key(0, rand_word(), rand_word());
      random_phase(1'b0);
      load_key($urandom_range(17, 31), rand_word(), rand_word());
      random_phase(1'b0);
      load_key($urandom_range(0, 31), rand_word(), rand_word());
      random_phase(1'b0);
      load_key($urandom_range(0, 31), rand_word(), rand_word());
      idle_on = 1'b0;
      random_phase(1'b0);

      wait_quiet();
      if (mismatches == 0 && outstanding == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         if (outstanding != 0)
            $display("%0t: %0d expected results never arrived", $time, outstanding);
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

[files.f]
hdl/rc4_pkg.sv
hdl/rc4_req_if.sv
hdl/rc4_rsp_if.sv
hdl/rc4_csr_if.sv
hdl/rc4_stream_cipher.sv
dv/rc4_cipher_checker.sv
dv/tb_rc4_stream_cipher.sv
